>>> rtl/core/mpsq_pkg.sv
// Package for the matrix power by squaring core.
// Holds payload structs, FSM state type, command/status structs and constants.
// No dependencies.
package mpsq_pkg;

	localparam int MAX_DIM_DEF   = 8;
	localparam int FRAC_BITS_DEF = 16;
	localparam int DIM_RESET     = 8;
	localparam int ADDR_W        = 3;

	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_START = 1'b1;

	localparam logic [ADDR_W-1:0] REG_DIMENSION = 3'd0;

	typedef struct packed {
		logic               kind;
		logic [2:0]         row_index;
		logic [2:0]         col_index;
		logic signed [31:0] element_value;
		logic [30:0]        exponent;
	} in_item_t;

	typedef struct packed {
		logic [2:0]         out_row;
		logic [2:0]         out_col;
		logic signed [31:0] out_value;
		logic               last;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_CHECK,
		ST_MUL,
		ST_COPY,
		ST_EMIT
	} state_t;

	// which product the datapath is forming
	typedef enum logic [1:0] {
		OP_ACC,
		OP_SQR
	} mop_t;

	typedef struct packed {
		logic load_base;
		logic init_clear;
		logic mul_begin;
		mop_t mul_op;
		logic copy_begin;
		logic emit_begin;
	} dp_cmd_t;

	typedef struct packed {
		logic init_done;
		logic mul_done;
		logic copy_done;
		logic emit_done;
	} dp_sts_t;

endpackage

>>> rtl/core/matrix_power_by_squaring_core.sv
// Matrix power by squaring core: n x n products on one shared multiply-accumulate unit.
// A start runs an init sweep, then up to 2*bits-1 products (each a check, an issue,
// n^3 MACs, a drain and a copy sweep), then n*n output transfers.
// Output runs one per cycle while out_ready is high; input waits for the last.
// Reset (arst_n, asynchronous) clears control; matrix stores are unset.
// Uses mpsq_pkg, mpsq_ctrl, mpsq_datapath.
module matrix_power_by_squaring_core #(
	parameter int MAX_DIM   = mpsq_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = mpsq_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  mpsq_pkg::in_item_t  in_data,
	output logic                out_valid,
	input  logic                out_ready,
	output mpsq_pkg::out_item_t out_data,
	input  logic                psel,
	input  logic                penable,
	input  logic                pwrite,
	input  logic [2:0]          paddr,
	input  logic [31:0]         pwdata,
	output logic [31:0]         prdata,
	output logic                pready
);
	import mpsq_pkg::*;

	logic [3:0] dim_q;
	logic [4:0] dim_n;
	dp_cmd_t    cmd;
	dp_sts_t    sts;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			dim_q <= 4'(DIM_RESET);
		else if (psel && penable && pwrite && paddr[2] == REG_DIMENSION[2] && paddr[1:0] == 2'b00)
			dim_q <= pwdata[3:0];
	end
	assign prdata = (paddr == REG_DIMENSION) ? {28'd0, dim_q} : 32'd0;
	assign dim_n  = (dim_q == 4'd0) ? 5'd1 : (32'(dim_q) > MAX_DIM) ? 5'(MAX_DIM) : {1'b0, dim_q};

	mpsq_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .in_item(in_data), .sts, .cmd
	);

	mpsq_datapath #(.MAX_DIM(MAX_DIM), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk, .arst_n, .cmd, .in_item(in_data), .dim_n, .sts,
		.o_valid(out_valid), .o_ready(out_ready), .o_item(out_data)
	);

endmodule

>>> rtl/core/mpsq_datapath.sv
// Datapath of the matrix power core: matrix stores, shared multiply-accumulate
// unit, copy and emit sweeps. Uses mpsq_pkg.
module mpsq_datapath #(
	parameter int MAX_DIM   = mpsq_pkg::MAX_DIM_DEF,
	parameter int FRAC_BITS = mpsq_pkg::FRAC_BITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  mpsq_pkg::dp_cmd_t   cmd,
	input  mpsq_pkg::in_item_t  in_item,
	input  logic [4:0]          dim_n,
	output mpsq_pkg::dp_sts_t   sts,
	output logic                o_valid,
	input  logic                o_ready,
	output mpsq_pkg::out_item_t o_item
);
	import mpsq_pkg::*;

	localparam int IW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int CELLS = MAX_DIM * MAX_DIM;
	localparam int AW    = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int SW    = 64 + IW + 1;

	logic signed [31:0] base_mem  [CELLS];
	logic signed [31:0] pow_mem   [CELLS];
	logic signed [31:0] acc_mem   [CELLS];
	logic signed [31:0] scr_mem   [CELLS];

	logic [IW-1:0] n_m1;
	assign n_m1 = IW'(dim_n - 5'd1);

	function automatic logic [AW-1:0] cell_addr(input logic [IW-1:0] r, input logic [IW-1:0] c);
		logic [AW-1:0] a;
		a = AW'(r) * AW'(MAX_DIM) + AW'(c);
		return a;
	endfunction

	// load
	always_ff @(posedge clk) begin
		if (cmd.load_base && 32'(in_item.row_index) < MAX_DIM
				&& 32'(in_item.col_index) < MAX_DIM)
			base_mem[cell_addr(IW'(in_item.row_index), IW'(in_item.col_index))] <=
				in_item.element_value;
	end

	// sweep counters
	logic          init_q, copy_q, mul_q, drain_q;
	logic [IW-1:0] ri_q, ci_q, ki_q;
	mop_t          op_q;
	logic signed [31:0] a_rd_q, b_rd_q;
	logic          rd_v_s1, rd_last_s1, p_v_s2, p_last_s2;
	logic [AW-1:0] rd_dst_s1, p_dst_s2, w_dst_s3;
	logic signed [63:0] prod_s2;
	logic signed [SW-1:0] sum_q;
	logic          w_v_s3;
	logic signed [31:0] w_val_s3;

	logic sweep_end;
	assign sweep_end = (ri_q == n_m1) && (ci_q == n_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q <= 1'b0;
			copy_q <= 1'b0;
			mul_q  <= 1'b0;
			ri_q   <= '0;
			ci_q   <= '0;
			ki_q   <= '0;
			op_q   <= OP_ACC;
		end else if (cmd.init_clear || cmd.copy_begin || cmd.mul_begin) begin
			init_q <= cmd.init_clear;
			copy_q <= cmd.copy_begin;
			mul_q  <= cmd.mul_begin;
			op_q   <= cmd.mul_op;
			ri_q   <= '0;
			ci_q   <= '0;
			ki_q   <= '0;
		end else if (init_q || copy_q) begin
			if (sweep_end) begin
				init_q <= 1'b0;
				copy_q <= 1'b0;
			end
			ci_q <= (ci_q == n_m1) ? '0 : ci_q + 1'b1;
			if (ci_q == n_m1)
				ri_q <= ri_q + 1'b1;
		end else if (mul_q) begin
			ki_q <= (ki_q == n_m1) ? '0 : ki_q + 1'b1;
			if (ki_q == n_m1) begin
				ci_q <= (ci_q == n_m1) ? '0 : ci_q + 1'b1;
				if (ci_q == n_m1)
					ri_q <= ri_q + 1'b1;
				if (sweep_end)
					mul_q <= 1'b0;
			end
		end
	end

	// init: accumulator to identity, power to base; copy: scratch to accumulator or power
	always_ff @(posedge clk) begin
		if (init_q) begin
			acc_mem[cell_addr(ri_q, ci_q)] <= (ri_q == ci_q) ? 32'sd1 <<< FRAC_BITS : 32'sd0;
			pow_mem[cell_addr(ri_q, ci_q)] <= base_mem[cell_addr(ri_q, ci_q)];
		end else if (copy_q) begin
			if (op_q == OP_ACC)
				acc_mem[cell_addr(ri_q, ci_q)] <= scr_mem[cell_addr(ri_q, ci_q)];
			else
				pow_mem[cell_addr(ri_q, ci_q)] <= scr_mem[cell_addr(ri_q, ci_q)];
		end
	end

	// stage 1: operand reads
	always_ff @(posedge clk) begin
		a_rd_q    <= (op_q == OP_ACC) ? acc_mem[cell_addr(ri_q, ki_q)] :
			pow_mem[cell_addr(ri_q, ki_q)];
		b_rd_q    <= pow_mem[cell_addr(ki_q, ci_q)];
		rd_dst_s1 <= cell_addr(ri_q, ci_q);
	end

	// stage 2: product
	logic signed [63:0] raw_prod;
	logic [63:0]        mag;
	assign raw_prod = 64'(a_rd_q) * 64'(b_rd_q);
	assign mag      = raw_prod[63] ? 64'(-raw_prod) >> FRAC_BITS : 64'(raw_prod) >> FRAC_BITS;

	always_ff @(posedge clk) begin
		prod_s2  <= raw_prod[63] ? -$signed(mag) : $signed(mag);
		p_dst_s2 <= rd_dst_s1;
	end

	// stage 3: accumulate and saturate
	logic signed [SW-1:0] nsum;
	assign nsum = sum_q + SW'(prod_s2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_v_s1    <= 1'b0;
			rd_last_s1 <= 1'b0;
			p_v_s2     <= 1'b0;
			p_last_s2  <= 1'b0;
			w_v_s3     <= 1'b0;
			drain_q    <= 1'b0;
			sum_q      <= '0;
		end else begin
			rd_v_s1    <= mul_q && !cmd.mul_begin;
			rd_last_s1 <= mul_q && (ki_q == n_m1);
			p_v_s2     <= rd_v_s1;
			p_last_s2  <= rd_last_s1;
			w_v_s3     <= p_v_s2 && p_last_s2;
			drain_q    <= mul_q;
			if (p_v_s2)
				sum_q <= p_last_s2 ? '0 : nsum;
		end
	end

	always_ff @(posedge clk) begin
		if (p_v_s2 && p_last_s2) begin
			w_dst_s3 <= p_dst_s2;
			if (nsum > SW'(64'sh7FFF_FFFF))
				w_val_s3 <= 32'sh7FFF_FFFF;
			else if (nsum < -SW'(64'sh8000_0000))
				w_val_s3 <= 32'sh8000_0000;
			else
				w_val_s3 <= nsum[31:0];
		end
		if (w_v_s3)
			scr_mem[w_dst_s3] <= w_val_s3;
	end

	// emit sweep with output register
	logic          emit_q, eo_end;
	logic [IW-1:0] er_q, ec_q;
	assign eo_end = (er_q == n_m1) && (ec_q == n_m1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			emit_q  <= 1'b0;
			er_q    <= '0;
			ec_q    <= '0;
			o_valid <= 1'b0;
		end else begin
			if (cmd.emit_begin) begin
				emit_q <= 1'b1;
				er_q   <= '0;
				ec_q   <= '0;
			end else if (emit_q && (!o_valid || o_ready)) begin
				o_valid <= 1'b1;
				ec_q <= (ec_q == n_m1) ? '0 : ec_q + 1'b1;
				if (ec_q == n_m1)
					er_q <= er_q + 1'b1;
				if (eo_end)
					emit_q <= 1'b0;
			end else if (o_valid && o_ready)
				o_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_q && (!o_valid || o_ready)) begin
			o_item.out_row   <= 3'(er_q);
			o_item.out_col   <= 3'(ec_q);
			o_item.out_value <= acc_mem[cell_addr(er_q, ec_q)];
			o_item.last      <= eo_end;
		end
	end

	assign sts.init_done = init_q && sweep_end;
	assign sts.copy_done = copy_q && sweep_end;
	assign sts.mul_done  = !mul_q && !drain_q && !rd_v_s1 && !p_v_s2 && !w_v_s3;
	assign sts.emit_done = !emit_q && (!o_valid || o_ready);

endmodule

>>> rtl/core/mpsq_ctrl.sv
// Controller FSM of the matrix power core: sequences init, products,
// copies and emission. Uses mpsq_pkg.
module mpsq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  mpsq_pkg::in_item_t in_item,
	input  mpsq_pkg::dp_sts_t  sts,
	output mpsq_pkg::dp_cmd_t  cmd
);
	import mpsq_pkg::*;

	state_t state_q, state_d;
	logic [30:0] bits_q;
	mop_t        op_q;
	logic        issued_q;
	logic        take;

	assign in_ready = (state_q == ST_IDLE);
	assign take     = in_valid && in_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:  if (take && in_item.kind == KIND_START) state_d = ST_INIT;
			ST_INIT:  if (sts.init_done) state_d = ST_CHECK;
			ST_CHECK: state_d = (bits_q == '0) ? ST_EMIT : ST_MUL;
			ST_MUL:   if (issued_q && sts.mul_done) state_d = ST_COPY;
			ST_COPY:  if (issued_q && sts.copy_done) state_d = ST_CHECK;
			ST_EMIT:  if (issued_q && sts.emit_done) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.mul_op     = op_q;
		cmd.load_base  = take && in_item.kind == KIND_LOAD;
		cmd.init_clear = take && in_item.kind == KIND_START;
		cmd.mul_begin  = (state_q == ST_MUL) && !issued_q;
		cmd.copy_begin = (state_q == ST_COPY) && !issued_q;
		cmd.emit_begin = (state_q == ST_EMIT) && !issued_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			bits_q   <= '0;
			op_q     <= OP_ACC;
			issued_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			issued_q <= (state_d == state_q) && (state_q == ST_MUL || state_q == ST_COPY
				|| state_q == ST_EMIT);
			if (take && in_item.kind == KIND_START)
				bits_q <= in_item.exponent;
			if (state_q == ST_CHECK && bits_q != '0) begin
				if (bits_q[0]) begin
					op_q <= OP_ACC;
					bits_q[0] <= 1'b0;
				end else begin
					op_q   <= OP_SQR;
					bits_q <= bits_q >> 1;
				end
			end
		end
	end

endmodule

>>> rtl/core/mpsq_checker.sv
// Port checker for the matrix power core, bound to the top level.
// Uses mpsq_pkg.
module mpsq_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input mpsq_pkg::out_item_t out_data,
	input logic                pready
);
	import mpsq_pkg::*;

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("output dropped while stalled");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("input taken during emission");
	a_pready: assert property (@(posedge clk) disable iff (!arst_n) pready)
		else $error("pready low");

endmodule

bind matrix_power_by_squaring_core mpsq_checker u_chk (
	.clk, .arst_n, .in_ready, .out_valid, .out_ready, .out_data, .pready
);
